>>> sv/oal_pkg.sv
// ----------------------------------------------------------------------------
// oal_pkg
// shared types and constants of the ordered array list engine
// ----------------------------------------------------------------------------
package oal_pkg;

  localparam int DEPTH_DEF  = 1024;
  localparam int DATA_W_DEF = 32;
  localparam int KIND_W     = 3;
  localparam int POS_W      = 10;
  localparam int CNT_W      = 11;
  localparam int STATUS_W   = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);

  typedef enum logic [KIND_W-1:0] {
    K_INSERT   = 3'd0,
    K_FIND     = 3'd1,
    K_READ     = 3'd2,
    K_DEL_POS  = 3'd3,
    K_DEL_VAL  = 3'd4,
    K_REPLACE  = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_ILLEGAL   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic              exec;
    logic              legal;
    kind_t             kind;
    logic [POS_W-1:0]  pos;
  } cmd_t;

endpackage

>>> sv/ordered_array_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// ordered list of signed words with live marks held in a row of slot cells
//
//   port group   handshake          contents
//   in_*         in_valid/ready     kind, position, value, new_value
//   out_*        out_valid/ready    status, found_index, read_data,
//                                   match_count, slot_count
//   apb          psel/penable       capacity register at address 0
//
// one word passes through accept, the execute state, in which every cell
// shifts, marks or compares at once, the levels of the registered reduction
// tree and the result load, which holds until the previous result is taken
// a new word is taken while a finished result waits on out_ready
// synchronous active-low reset empties the list and sets capacity to 1024
// ----------------------------------------------------------------------------
module ordered_array_list_engine #(
  parameter int DEPTH      = oal_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = oal_pkg::DATA_W_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [oal_pkg::KIND_W-1:0]          in_kind,
  input  logic [oal_pkg::POS_W-1:0]           in_position,
  input  logic signed [DATA_WIDTH-1:0]        in_value,
  input  logic signed [DATA_WIDTH-1:0]        in_new_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [oal_pkg::STATUS_W-1:0]        out_status,
  output logic [oal_pkg::POS_W-1:0]           out_found_index,
  output logic signed [DATA_WIDTH-1:0]        out_read_data,
  output logic [oal_pkg::CNT_W-1:0]           out_match_count,
  output logic [oal_pkg::CNT_W-1:0]           out_slot_count,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [oal_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [oal_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [oal_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import oal_pkg::*;

  localparam int LV    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > CNT_W) ? CW : CNT_W;
  localparam int RED_W = $clog2(LV + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REDUCE
  } state_t;

  state_t                state_r;
  logic [CW-1:0]         used_r;
  logic [CNT_W-1:0]      cap_r;
  logic [RED_W-1:0]      red_cnt_r;
  kind_t                 kind_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [DATA_WIDTH-1:0] nval_r;
  status_t               pre_st_r;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [POS_W-1:0]      out_found_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  logic [CNT_W-1:0]      out_match_r;
  logic [CNT_W-1:0]      out_slots_r;

  cmd_t                  cmd;
  status_t               pre_st;
  kind_t                 in_kind_c;
  logic [CMP_W-1:0]      used_ext;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cap_eff;
  logic                  cfg_wr;
  logic                  found_any;
  logic                  res_load;
  status_t               res_st;

  logic [DEPTH-1:0][DATA_WIDTH-1:0] word_q;
  logic [DEPTH-1:0]                 live_q;
  logic [DEPTH-1:0]                 hit_q;
  logic [DEPTH-1:0][DATA_WIDTH-1:0] data_q;
  logic [CW-1:0]                    root_cnt;
  logic [LV-1:0]                    root_idx;
  logic [DATA_WIDTH-1:0]            root_data;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (reg_idx_t'(paddr[2]) == REG_CAPACITY) ? CFG_DATA_W'(cap_r) : '0;

  // legality checks at accept
  assign in_kind_c = kind_t'(in_kind);
  assign used_ext  = CMP_W'(used_r);
  assign pos_ext   = CMP_W'(in_position);
  assign cap_eff   = (CMP_W'(cap_r) < CMP_W'(DEPTH)) ? CMP_W'(cap_r) : CMP_W'(DEPTH);

  always_comb begin
    pre_st = ST_OK;
    case (in_kind_c)
      K_INSERT: begin
        if (used_ext >= cap_eff) pre_st = ST_FULL;
        else if (pos_ext > used_ext) pre_st = ST_ILLEGAL;
      end
      K_READ, K_DEL_POS: begin
        if (pos_ext >= used_ext) pre_st = ST_ILLEGAL;
      end
      default: pre_st = ST_OK;
    endcase
  end

  assign cmd.exec  = (state_r == S_EXEC);
  assign cmd.legal = (pre_st_r == ST_OK);
  assign cmd.kind  = kind_r;
  assign cmd.pos   = pos_r;

  // slot cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_word;
    logic                  prev_live;
    if (i == 0) begin : g_first
      assign prev_word = '0;
      assign prev_live = 1'b0;
    end else begin : g_next
      assign prev_word = word_q[i-1];
      assign prev_live = live_q[i-1];
    end
    oal_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH),
      .USED_W     (CW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .value     (val_r),
      .new_value (nval_r),
      .used      (used_r),
      .prev_word (prev_word),
      .prev_live (prev_live),
      .word_o    (word_q[i]),
      .live_o    (live_q[i]),
      .hit_o     (hit_q[i]),
      .data_o    (data_q[i])
    );
  end

  oal_tree #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .LV         (LV),
    .CW         (CW)
  ) u_tree (
    .clk       (clk),
    .leaf_hit  (hit_q),
    .leaf_data (data_q),
    .root_cnt  (root_cnt),
    .root_idx  (root_idx),
    .root_data (root_data)
  );

  assign found_any = (root_cnt != '0);

  always_comb begin
    case (kind_r)
      K_INSERT, K_READ, K_DEL_POS:   res_st = pre_st_r;
      K_FIND, K_DEL_VAL, K_REPLACE:  res_st = found_any ? ST_OK : ST_NOT_FOUND;
      default:                       res_st = ST_OK;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign res_load = (state_r == S_REDUCE) && (red_cnt_r == '0) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      cap_r       <= CAP_RESET;
      red_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && (reg_idx_t'(paddr[2]) == REG_CAPACITY)) cap_r <= pwdata[CNT_W-1:0];
      if (res_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r   <= in_kind_c;
            pos_r    <= in_position;
            val_r    <= in_value;
            nval_r   <= in_new_value;
            pre_st_r <= pre_st;
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if ((kind_r == K_INSERT) && (pre_st_r == ST_OK)) used_r <= used_r + 1'b1;
          red_cnt_r <= RED_W'(LV);
          state_r   <= S_REDUCE;
        end
        S_REDUCE: begin
          if (red_cnt_r != '0) begin
            red_cnt_r <= red_cnt_r - 1'b1;
          end else if (res_load) begin
            out_status_r <= res_st;
            out_found_r  <= ((kind_r == K_FIND) && found_any) ? POS_W'(root_idx) : '0;
            out_data_r   <= root_data;
            out_match_r  <= ((kind_r == K_DEL_VAL) || (kind_r == K_REPLACE)) ?
                            CNT_W'(root_cnt) : '0;
            out_slots_r  <= CNT_W'(used_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;
  assign out_read_data   = out_data_r;
  assign out_match_count = out_match_r;
  assign out_slot_count  = out_slots_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(used_r) <= CMP_W'(DEPTH))
    else $error("slot count above depth");

  a_used_change: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(used_r) |-> $past(state_r == S_EXEC))
    else $error("slot count changed outside execute cycle");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && (kind_r == K_INSERT) && (pre_st_r == ST_OK)
    |=> used_r == $past(used_r) + 1'b1)
    else $error("legal insert did not grow the list");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r == S_REDUCE))
    else $error("result loaded before reduction finished");

endmodule

>>> sv/oal_cell.sv
// ----------------------------------------------------------------------------
// oal_cell
// one slot of the list: word, live mark, match and read-select flags
// ----------------------------------------------------------------------------
module oal_cell #(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = oal_pkg::DATA_W_DEF,
  parameter int USED_W     = oal_pkg::CNT_W
) (
  input  logic                  clk,
  input  oal_pkg::cmd_t         cmd,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] new_value,
  input  logic [USED_W-1:0]     used,
  input  logic [DATA_WIDTH-1:0] prev_word,
  input  logic                  prev_live,
  output logic [DATA_WIDTH-1:0] word_o,
  output logic                  live_o,
  output logic                  hit_o,
  output logic [DATA_WIDTH-1:0] data_o
);
  import oal_pkg::*;

  localparam int CMP_W = (USED_W > CNT_W) ? USED_W : CNT_W;
  localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

  logic [DATA_WIDTH-1:0] word_r;
  logic                  live_r;
  logic                  hit_r;
  logic                  pick_r;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      used_ext;
  logic                  at_pos;
  logic                  above_pos;
  logic                  in_list;
  logic                  match;
  logic                  pick;

  assign pos_ext   = CMP_W'(cmd.pos);
  assign used_ext  = CMP_W'(used);
  assign at_pos    = (IDX == pos_ext);
  assign above_pos = (IDX > pos_ext);
  assign in_list   = (IDX < used_ext);
  assign match     = live_r && in_list && (word_r == value);
  assign pick      = (pos_ext < used_ext) ? at_pos : ((IDX == '0) && (used_ext != '0));

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      hit_r  <= match && ((cmd.kind == K_FIND) || (cmd.kind == K_DEL_VAL) ||
                          (cmd.kind == K_REPLACE));
      pick_r <= pick && (cmd.kind == K_READ);
      case (cmd.kind)
        K_INSERT: begin
          if (cmd.legal && at_pos) begin
            word_r <= value;
            live_r <= 1'b1;
          end else if (cmd.legal && above_pos) begin
            word_r <= prev_word;
            live_r <= prev_live;
          end
        end
        K_DEL_POS: begin
          if (cmd.legal && at_pos) live_r <= 1'b0;
        end
        K_DEL_VAL: begin
          if (match) live_r <= 1'b0;
        end
        K_REPLACE: begin
          if (match) word_r <= new_value;
        end
        default: ;
      endcase
    end
  end

  assign word_o = word_r;
  assign live_o = live_r;
  assign hit_o  = hit_r;
  assign data_o = pick_r ? word_r : '0;

endmodule

>>> sv/oal_tree.sv
// ----------------------------------------------------------------------------
// oal_tree
// registered binary tree: hit count, first hit index and or of picked words
// ----------------------------------------------------------------------------
module oal_tree #(
  parameter int DEPTH      = oal_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = oal_pkg::DATA_W_DEF,
  parameter int LV         = $clog2(DEPTH),
  parameter int CW         = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic [DEPTH-1:0]                 leaf_hit,
  input  logic [DEPTH-1:0][DATA_WIDTH-1:0] leaf_data,
  output logic [CW-1:0]                    root_cnt,
  output logic [LV-1:0]                    root_idx,
  output logic [DATA_WIDTH-1:0]            root_data
);

  localparam int P = 1 << LV;

  logic [CW-1:0]         lf_cnt  [P];
  logic [DATA_WIDTH-1:0] lf_data [P];

  logic [CW-1:0]         nd_cnt_r  [1:P-1];
  logic [LV-1:0]         nd_idx_r  [1:P-1];
  logic [DATA_WIDTH-1:0] nd_data_r [1:P-1];

  logic [CW-1:0]         all_cnt  [1:2*P-1];
  logic [LV-1:0]         all_idx  [1:2*P-1];
  logic [DATA_WIDTH-1:0] all_data [1:2*P-1];

  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < DEPTH) begin : g_real
      assign lf_cnt[j]  = CW'(leaf_hit[j]);
      assign lf_data[j] = leaf_data[j];
    end else begin : g_pad
      assign lf_cnt[j]  = '0;
      assign lf_data[j] = '0;
    end
  end

  always_comb begin
    for (int n = 1; n < P; n++) begin
      all_cnt[n]  = nd_cnt_r[n];
      all_idx[n]  = nd_idx_r[n];
      all_data[n] = nd_data_r[n];
    end
    for (int j = 0; j < P; j++) begin
      all_cnt[P+j]  = lf_cnt[j];
      all_idx[P+j]  = LV'(j);
      all_data[P+j] = lf_data[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int n = 1; n < P; n++) begin
      nd_cnt_r[n]  <= all_cnt[2*n] + all_cnt[2*n+1];
      nd_idx_r[n]  <= (all_cnt[2*n] != '0) ? all_idx[2*n] : all_idx[2*n+1];
      nd_data_r[n] <= all_data[2*n] | all_data[2*n+1];
    end
  end

  assign root_cnt  = nd_cnt_r[1];
  assign root_idx  = nd_idx_r[1];
  assign root_data = nd_data_r[1];

endmodule
